/* hdl/dvg_pkg.sv */
// Shared types, register indexes and reset values for the detection validity gate.
`default_nettype none

package dvg_pkg;

    // Tracking mode reported with each result beat
    typedef enum logic [1:0] {
        MODE_IDLING   = 2'd0,
        MODE_TRACKING = 2'd1,
        MODE_STOPPING = 2'd2
    } mode_t;

    // Controller sequence
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } ctrl_state_t;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOCK_IN_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RANGE_MM  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_RANGE_MM  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_SHIFT_MM  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_GAP_MS    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_HISTORY_LEN   = 3'd5;
    localparam int CFG_DATA_W = 16;

    // Register values after reset
    localparam logic [7:0]  RST_LOCK_IN_COUNT = 8'd3;
    localparam logic [15:0] RST_MAX_RANGE_MM  = 16'd10000;
    localparam logic [15:0] RST_MIN_RANGE_MM  = 16'd500;
    localparam logic [15:0] RST_MAX_SHIFT_MM  = 16'd500;
    localparam logic [15:0] RST_MAX_GAP_MS    = 16'd100;
    localparam logic [5:0]  RST_HISTORY_LEN   = 6'd20;

    // Result beat: reset_filter, aim_state, lock_level padded to whole bytes
    localparam int OUT_W = 16;

    // Stages from distance unit input to its registered flags
    localparam int DIST_LATENCY = 3;

    // Control riding alongside one distance unit operand
    typedef struct packed {
        logic valid;
        logic is_range;
    } dist_tag_t;

    // Flags returned by the distance unit
    typedef struct packed {
        logic valid;
        logic is_range;
        logic out_of_range;
        logic near;
    } dist_res_t;

endpackage

`default_nettype wire

/* hdl/dvg_cell.sv */
// One history cell: holds a position, passes it to its neighbour while rotating.
`default_nettype none

module dvg_cell
    import dvg_pkg::*;
#(
    parameter int DATA_W = 48
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              shift_en,
    input  wire logic              load_en,
    input  wire logic [DATA_W-1:0] shift_in,
    input  wire logic [DATA_W-1:0] load_data,
    output logic      [DATA_W-1:0] data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // Take the neighbour's entry while rotating, the new detection on load
    always_comb
    begin
        data_next = data_reg;
        if (load_en)
        begin
            data_next = load_data;
        end
        else if (shift_en)
        begin
            data_next = shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

endmodule

`default_nettype wire

/* hdl/dvg_dist.sv */
// Shared squared-distance unit: three stages, flags against range and shift limits.
`default_nettype none

module dvg_dist
    import dvg_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dist_tag_t             tag_in,
    input  wire logic [COORD_BITS-1:0] qx,
    input  wire logic [COORD_BITS-1:0] qy,
    input  wire logic [COORD_BITS-1:0] qz,
    input  wire logic [COORD_BITS-1:0] ex,
    input  wire logic [COORD_BITS-1:0] ey,
    input  wire logic [COORD_BITS-1:0] ez,
    input  wire logic [15:0]           min_range,
    input  wire logic [15:0]           max_range,
    input  wire logic [15:0]           max_shift,
    output dist_res_t                  res
);

    localparam int C     = COORD_BITS;
    localparam int SQ_W  = 2 * C;
    localparam int SUM_W = 2 * C + 2;
    localparam int CMP_W = (SUM_W > 32) ? SUM_W : 32;

    logic [2:0][C-1:0] q_vec;
    logic [2:0][C-1:0] e_vec;
    logic [2:0][C-1:0] mag_next;
    logic [2:0][C-1:0] mag_reg;
    logic [2:0][SQ_W-1:0] sq_next;
    logic [2:0][SQ_W-1:0] sq_reg;
    logic [SUM_W-1:0] sum_next;
    logic [CMP_W-1:0] sum_cmp;
    logic [31:0] lo_sq_reg;
    logic [31:0] hi_sq_reg;
    logic [31:0] lim_sq_reg;
    dist_tag_t tag_a_reg;
    dist_tag_t tag_b_reg;
    dist_res_t res_next;
    dist_res_t res_reg;

    assign q_vec = {qz, qy, qx};
    assign e_vec = {ez, ey, ex};

    // Square the limits; the user moves configuration only while idle; not enforced
    always_ff @(posedge clk)
    begin
        lo_sq_reg  <= min_range * min_range;
        hi_sq_reg  <= max_range * max_range;
        lim_sq_reg <= max_shift * max_shift;
    end

    // Stage A: per-axis difference and magnitude
    always_comb
    begin
        logic [C:0] diff;
        logic [C:0] neg;
        for (int a = 0; a < 3; a++)
        begin
            diff = {q_vec[a][C-1], q_vec[a]} - {e_vec[a][C-1], e_vec[a]};
            neg  = (~diff) + 1'b1;
            mag_next[a] = diff[C] ? neg[C-1:0] : diff[C-1:0];
        end
    end

    // Stage B: per-axis square
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            sq_next[a] = mag_reg[a] * mag_reg[a];
        end
    end

    // Stage C: sum and compare against the limits
    always_comb
    begin
        sum_next = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
        sum_cmp  = CMP_W'(sum_next);
        res_next.valid        = tag_b_reg.valid;
        res_next.is_range     = tag_b_reg.is_range;
        res_next.out_of_range = (sum_cmp > CMP_W'(hi_sq_reg)) ||
                                (sum_cmp < CMP_W'(lo_sq_reg));
        res_next.near         = sum_cmp < CMP_W'(lim_sq_reg);
    end

    // Hold the operands of each stage
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        sq_reg  <= sq_next;
    end

    // Advance the tags with their operands
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            res_reg   <= '0;
        end
        else
        begin
            tag_a_reg <= tag_in;
            tag_b_reg <= tag_a_reg;
            res_reg   <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

/* hdl/detection_validity_gate.sv */
// Top level of the detection validity gate: config, history ring, control and result beat.
//
// Use: each input beat on s_* carries one detection (x, y, z in mm, millisecond
// timestamp). The block range-checks it, times it out against the last valid
// detection, and compares it with a ring of recent detections; one result beat
// on m_* follows per detection with the filter-reset flag, tracking mode and
// lock-in counter. Registers are written on the cfg_* channel; the user must
// do so only while idle, and the block itself does not enforce it. Each accepted
// beat is scanned, the distance unit is drained and the decision is committed to
// the result register; a new detection is taken only after that commit. The ring of
// HISTORY_DEPTH cells rotates once per detection past a single shared
// squared-distance unit, which also takes the range check in its first slot,
// and the unit's three-stage pipeline is drained before the decision.
// Reset: all registers return to their reset values, the ring clears to zero,
// mode is stopping, counter and last-valid time are zero; cfg_ready is always high.
// Stall: a result waiting on m_tready does not block the next input beat; that
// detection is scanned and holds in its final cycle until the output register frees.
`default_nettype none

module detection_validity_gate
    import dvg_pkg::*;
#(
    parameter int HISTORY_DEPTH = 32,
    parameter int COORD_BITS    = 16
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // fields from bit 0: pos_x, pos_y, pos_z (COORD_BITS each), time_ms (32), zero pad
    input  wire logic [((3*COORD_BITS+32+7)/8)*8-1:0] s_tdata,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // fields from bit 0: reset_filter (1), aim_state (2), lock_level (8), zero pad
    output logic [OUT_W-1:0]               m_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     cfg_data
);

    localparam int C       = COORD_BITS;
    localparam int ENTRY_W = 3 * C;
    localparam int SLOT_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);

    // Configuration registers
    logic [7:0]  lock_in_reg;
    logic [15:0] max_range_reg;
    logic [15:0] min_range_reg;
    logic [15:0] max_shift_reg;
    logic [15:0] max_gap_reg;
    logic [5:0]  history_len_reg;

    // Control
    ctrl_state_t      state_reg;
    ctrl_state_t      state_next;
    logic [CNT_W-1:0] step_reg;
    logic [1:0]       drain_reg;
    logic             feed_en;
    logic             rotate;
    logic             commit;
    logic             accept;

    // Query and accumulated flags
    logic [C-1:0]  qx_reg;
    logic [C-1:0]  qy_reg;
    logic [C-1:0]  qz_reg;
    logic [31:0]   time_reg;
    logic          near_reg;
    logic          range_bad_reg;

    // Gate state
    logic [7:0]        lock_reg;
    logic [7:0]        lock_next;
    mode_t             mode_reg;
    mode_t             mode_next;
    logic [31:0]       last_valid_reg;
    logic [31:0]       last_valid_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;

    // Output register
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic [OUT_W-1:0] out_data_next;

    // Ring and distance unit
    logic [ENTRY_W-1:0] ring_data [HISTORY_DEPTH];
    logic [ENTRY_W-1:0] query_entry;
    logic [ENTRY_W-1:0] probe_entry;
    logic [6:0]         n_len;
    dist_tag_t          tag;
    dist_res_t          res;

    logic [31:0] gap;
    logic        timeout;
    logic        invalid;
    logic [8:0]  up_count;
    logic [6:0]  slot_plus;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_in_reg     <= RST_LOCK_IN_COUNT;
            max_range_reg   <= RST_MAX_RANGE_MM;
            min_range_reg   <= RST_MIN_RANGE_MM;
            max_shift_reg   <= RST_MAX_SHIFT_MM;
            max_gap_reg     <= RST_MAX_GAP_MS;
            history_len_reg <= RST_HISTORY_LEN;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LOCK_IN_COUNT: lock_in_reg     <= cfg_data[7:0];
                CFG_MAX_RANGE_MM:  max_range_reg   <= cfg_data;
                CFG_MIN_RANGE_MM:  min_range_reg   <= cfg_data;
                CFG_MAX_SHIFT_MM:  max_shift_reg   <= cfg_data;
                CFG_MAX_GAP_MS:    max_gap_reg     <= cfg_data;
                CFG_HISTORY_LEN:   history_len_reg <= cfg_data[5:0];
                default:           ;
            endcase
        end
    end

    // Clamp the history length to one..HISTORY_DEPTH
    always_comb
    begin
        if (history_len_reg == 6'd0)
        begin
            n_len = 7'd1;
        end
        else if ({1'b0, history_len_reg} > 7'(HISTORY_DEPTH))
        begin
            n_len = 7'(HISTORY_DEPTH);
        end
        else
        begin
            n_len = {1'b0, history_len_reg};
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (step_reg == CNT_W'(HISTORY_DEPTH))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_reg == 2'(DIST_LATENCY - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs of the sequence
    always_comb
    begin
        s_tready = 1'b0;
        feed_en  = 1'b0;
        rotate   = 1'b0;
        commit   = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_SCAN:
            begin
                feed_en = 1'b1;
                rotate  = (step_reg != '0);
            end
            ST_DRAIN: ;
            ST_DONE:  commit = !out_valid_reg || m_tready;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Step and drain counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            drain_reg <= '0;
        end
        else
        begin
            if (state_reg == ST_SCAN)
            begin
                step_reg  <= step_reg + 1'b1;
                drain_reg <= '0;
            end
            else
            begin
                step_reg <= '0;
                if (state_reg == ST_DRAIN)
                begin
                    drain_reg <= drain_reg + 1'b1;
                end
            end
        end
    end

    // Hold the accepted detection
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            qx_reg   <= s_tdata[C-1:0];
            qy_reg   <= s_tdata[2*C-1:C];
            qz_reg   <= s_tdata[3*C-1:2*C];
            time_reg <= s_tdata[3*C+31:3*C];
        end
    end

    assign query_entry = {qz_reg, qy_reg, qx_reg};

    // History ring: cell zero faces the distance unit
    for (genvar i = 0; i < HISTORY_DEPTH; i++)
    begin : g_ring
        dvg_cell #(
            .DATA_W (ENTRY_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift_en  (rotate),
            .load_en   (commit && (slot_reg == SLOT_W'(i))),
            .shift_in  (ring_data[(i + 1) % HISTORY_DEPTH]),
            .load_data (query_entry),
            .data      (ring_data[i])
        );
    end

    // First slot is the range check against the origin, then the entries in order
    always_comb
    begin
        probe_entry  = (step_reg == '0) ? '0 : ring_data[0];
        tag.is_range = (step_reg == '0);
        tag.valid    = feed_en && ((step_reg == '0) || (7'(step_reg) <= n_len));
    end

    dvg_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag_in    (tag),
        .qx        (qx_reg),
        .qy        (qy_reg),
        .qz        (qz_reg),
        .ex        (probe_entry[C-1:0]),
        .ey        (probe_entry[2*C-1:C]),
        .ez        (probe_entry[3*C-1:2*C]),
        .min_range (min_range_reg),
        .max_range (max_range_reg),
        .max_shift (max_shift_reg),
        .res       (res)
    );

    // Collect the range flag and any near hit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_reg      <= 1'b0;
            range_bad_reg <= 1'b0;
        end
        else if (accept)
        begin
            near_reg      <= 1'b0;
            range_bad_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            if (res.is_range)
            begin
                range_bad_reg <= res.out_of_range;
            end
            else if (res.near)
            begin
                near_reg <= 1'b1;
            end
        end
    end

    // Decide: range, then timeout, then shift
    always_comb
    begin
        gap       = time_reg - last_valid_reg;
        timeout   = gap > {16'd0, max_gap_reg};
        up_count  = {1'b0, lock_reg} + 9'd1;
        lock_next       = lock_reg;
        mode_next       = mode_reg;
        last_valid_next = last_valid_reg;
        invalid         = 1'b1;
        if (range_bad_reg || (!timeout && !near_reg))
        begin
            if (lock_reg <= 8'd1)
            begin
                lock_next = 8'd0;
                mode_next = MODE_STOPPING;
            end
            else
            begin
                lock_next = lock_reg - 8'd1;
                mode_next = MODE_IDLING;
            end
        end
        else if (timeout)
        begin
            lock_next       = 8'd0;
            mode_next       = MODE_STOPPING;
            last_valid_next = time_reg;
        end
        else
        begin
            invalid         = 1'b0;
            last_valid_next = time_reg;
            if (up_count >= {1'b0, lock_in_reg})
            begin
                lock_next = lock_in_reg;
                mode_next = MODE_TRACKING;
            end
            else
            begin
                lock_next = up_count[7:0];
                mode_next = MODE_IDLING;
            end
        end
        out_data_next = {5'd0, lock_next, mode_next,
                         invalid && (mode_next != MODE_STOPPING)};
    end

    // Advance the write slot, wrapping at the clamped length
    always_comb
    begin
        slot_plus = 7'(slot_reg) + 7'd1;
        slot_next = (slot_plus >= n_len) ? '0 : SLOT_W'(slot_plus);
    end

    // Commit gate state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_reg       <= 8'd0;
            mode_reg       <= MODE_STOPPING;
            last_valid_reg <= 32'd0;
            slot_reg       <= '0;
        end
        else if (commit)
        begin
            lock_reg       <= lock_next;
            mode_reg       <= mode_next;
            last_valid_reg <= last_valid_next;
            slot_reg       <= slot_next;
        end
    end

    // Result beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Stopping always carries a cleared counter
    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_STOPPING) |-> (lock_reg == 8'd0))
        else $error("stopping mode with non-zero lock counter");

    // Distance flags only arrive inside the scan window
    a_res_window: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> ((state_reg == ST_SCAN) || (state_reg == ST_DRAIN)))
        else $error("distance result outside scan window");

    // A commit loads the result beat and frees the input side
    a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (out_valid_reg && (state_reg == ST_IDLE)))
        else $error("commit did not present a result beat");

endmodule

`default_nettype wire
